// File: hw/rtl/fault_table_severity_mode_manager_unit_macros.svh
// assertion macros for the fault table and mode manager
// used by the datapath, expects clk and rst in the including scope
`ifndef FAULT_TABLE_SEVERITY_MODE_MANAGER_UNIT_MACROS_SVH
`define FAULT_TABLE_SEVERITY_MODE_MANAGER_UNIT_MACROS_SVH

// same-cycle implication
`define FTSM_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FTSM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ftsm_pkg.sv
// shared types, codes and the mode update rule of the fault table manager
// no dependencies
package ftsm_pkg;

  localparam int NUM_SEV = 5;

  // item operations
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_CLR    = 3'd1;
  localparam logic [2:0] OP_CLRALL = 3'd2;
  localparam logic [2:0] OP_FORCE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_EXISTING = 3'd1;
  localparam logic [2:0] ST_CLEARED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_HINVALID = 3'd6;

  // severities
  localparam logic [2:0] SEV_INFO  = 3'd0;
  localparam logic [2:0] SEV_ERROR = 3'd2;
  localparam logic [2:0] SEV_CRIT  = 3'd3;
  localparam logic [2:0] SEV_FATAL = 3'd4;

  // system modes
  localparam logic [3:0] MODE_INIT      = 4'd0;
  localparam logic [3:0] MODE_PREFLIGHT = 4'd1;
  localparam logic [3:0] MODE_ARMED     = 4'd2;
  localparam logic [3:0] MODE_FLIGHT    = 4'd3;
  localparam logic [3:0] MODE_RECOVERY  = 4'd4;
  localparam logic [3:0] MODE_LANDED    = 4'd5;
  localparam logic [3:0] MODE_ERROR     = 4'd6;
  localparam logic [3:0] MODE_CRITICAL  = 4'd7;
  localparam logic [3:0] MODE_SAFE      = 4'd8;
  localparam logic [3:0] MODE_DEBUG     = 4'd9;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
    logic hist_chk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] mode_update(input logic [3:0] cur, input logic [2:0] ms);
    logic [3:0] r;
    r = cur;
    if (!(cur inside {MODE_FLIGHT, MODE_RECOVERY, MODE_LANDED, MODE_DEBUG})) begin
      if (ms >= SEV_CRIT) begin
        r = MODE_SAFE;
      end else if (ms == SEV_ERROR) begin
        r = MODE_ERROR;
      end else if (ms == SEV_INFO && (cur inside {MODE_ERROR, MODE_SAFE})) begin
        r = MODE_PREFLIGHT;
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ftsm_ctrl.sv
// sequencer of the fault table manager: accept, scan, apply, read, finish
// depends on ftsm_pkg
module ftsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      op,
  input  ftsm_pkg::stat_t stat,
  output ftsm_pkg::cmd_t  cmd
);
  import ftsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_READ  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET, OP_CLR: state_next = S_SCAN;
            OP_READ:        state_next = S_READ;
            default:        state_next = S_APPLY;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_APPLY;
      end
      S_APPLY: state_next = S_FIN;
      S_READ:  state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.scan_step = (state == S_SCAN);
    cmd.apply     = (state == S_APPLY);
    cmd.hist_chk  = (state == S_READ);
    cmd.finish    = (state == S_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/ftsm_datapath.sv
// fault slots, severity counters, history ring, system mode and output word register
// depends on ftsm_pkg and the assertion macro header
`include "fault_table_severity_mode_manager_unit_macros.svh"

module ftsm_datapath #(
  parameter int ACTIVE_SLOTS  = 16,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ftsm_pkg::cmd_t                        cmd,
  output ftsm_pkg::stat_t                       stat,
  input  logic [2:0]                            mode,
  input  logic [7:0]                            fault_source,
  input  logic [15:0]                           fault_code,
  input  logic [2:0]                            severity,
  input  logic [3:0]                            forced_mode,
  input  logic [4:0]                            history_age,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            status,
  output logic [3:0]                            system_mode,
  output logic [2:0]                            max_severity,
  output logic [$clog2(ACTIVE_SLOTS+1)-1:0]     active_count,
  output logic                                  hist_valid,
  output logic [7:0]                            hist_source,
  output logic [15:0]                           hist_code,
  output logic [2:0]                            hist_severity
);
  import ftsm_pkg::*;

  localparam int SW   = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int CW   = $clog2(ACTIVE_SLOTS + 1);
  localparam int HW   = $clog2(HISTORY_DEPTH);
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int AW   = ((HW > 5) ? HW : 5) + 2;
  localparam int SUMW = CW + 3;

  // latched item
  logic [2:0]  op_q;
  logic [7:0]  src_q;
  logic [15:0] code_q;
  logic [2:0]  sev_q;
  logic [3:0]  fm_q;
  logic [4:0]  age_q;

  // slot table
  logic [ACTIVE_SLOTS-1:0] slot_used;
  logic [7:0]              slot_src [ACTIVE_SLOTS];
  logic [15:0]             slot_code[ACTIVE_SLOTS];
  logic [2:0]              slot_sev [ACTIVE_SLOTS];

  // scan trackers
  logic [SW-1:0] idx;
  logic          found_q, free_q;
  logic [SW-1:0] found_idx, free_idx;
  logic [2:0]    found_sev;
  logic          hit_now;

  // per-severity population and totals
  logic [CW-1:0]   sev_cnt[NUM_SEV];
  logic [CW-1:0]   active_q;
  logic [2:0]      max_sev;
  logic [SUMW-1:0] cnt_sum;

  // history ring
  logic [26:0]   ring[HISTORY_DEPTH];
  logic [26:0]   rd_data;
  logic [HW-1:0] head;
  logic [FW-1:0] fill;
  logic [AW-1:0] rd_sum, rd_wrap;
  logic [HW-1:0] rd_addr;
  logic          hist_hit;

  logic [3:0] cur_mode, new_mode;
  logic [2:0] st_q;
  logic       upd_q, hv_q;

  logic                do_ins, do_raise, do_clr, do_clrall;
  logic [NUM_SEV-1:0]  inc_vec, dec_vec;
  logic                out_valid_q;

  assign hit_now = slot_used[idx] && (slot_src[idx] == src_q) && (slot_code[idx] == code_q);

  assign stat.scan_last = (idx == SW'(ACTIVE_SLOTS - 1));
  assign stat.out_free  = !out_valid_q || !out_stall;

  // ring index of the event age_q places back from the newest, head stays below the depth
  assign rd_sum   = AW'(head) + AW'(HISTORY_DEPTH - 1) - AW'(age_q);
  assign rd_wrap  = (rd_sum >= AW'(HISTORY_DEPTH)) ? rd_sum - AW'(HISTORY_DEPTH) : rd_sum;
  assign rd_addr  = rd_wrap[HW-1:0];
  assign hist_hit = AW'(age_q) < AW'(fill);

  always_comb begin
    do_ins    = cmd.apply && (op_q == OP_SET) && !found_q && free_q;
    do_raise  = cmd.apply && (op_q == OP_SET) && found_q && (sev_q > found_sev);
    do_clr    = cmd.apply && (op_q == OP_CLR) && found_q;
    do_clrall = cmd.apply && (op_q == OP_CLRALL);
    for (int j = 0; j < NUM_SEV; j++) begin
      inc_vec[j] = (do_ins || do_raise) && (sev_q == 3'(j));
      dec_vec[j] = (do_raise || do_clr) && (found_sev == 3'(j));
    end
  end

  always_comb begin
    max_sev = SEV_INFO;
    cnt_sum = '0;
    for (int j = 0; j < NUM_SEV; j++) begin
      if (sev_cnt[j] != '0) max_sev = 3'(j);
      cnt_sum = cnt_sum + SUMW'(sev_cnt[j]);
    end
  end

  assign new_mode = upd_q ? mode_update(cur_mode, max_sev) : cur_mode;

  // item capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= mode;
      src_q   <= fault_source;
      code_q  <= fault_code;
      sev_q   <= (severity > SEV_FATAL) ? SEV_FATAL : severity;
      fm_q    <= forced_mode;
      age_q   <= history_age;
      idx     <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + SW'(1);
      if (hit_now && !found_q) begin
        found_q   <= 1'b1;
        found_idx <= idx;
        found_sev <= slot_sev[idx];
      end
      if (!slot_used[idx] && !free_q) begin
        free_q   <= 1'b1;
        free_idx <= idx;
      end
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (do_ins) begin
      slot_src[free_idx]  <= src_q;
      slot_code[free_idx] <= code_q;
      slot_sev[free_idx]  <= sev_q;
    end
    if (do_raise) begin
      slot_sev[found_idx] <= sev_q;
    end
  end

  // history ring storage
  always_ff @(posedge clk) begin
    if (do_ins) begin
      ring[head] <= {src_q, code_q, sev_q};
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      active_q  <= '0;
      head      <= '0;
      fill      <= '0;
      cur_mode  <= MODE_INIT;
      for (int j = 0; j < NUM_SEV; j++) sev_cnt[j] <= '0;
    end else begin
      if (do_clrall) begin
        slot_used <= '0;
        active_q  <= '0;
        for (int j = 0; j < NUM_SEV; j++) sev_cnt[j] <= '0;
      end else begin
        for (int j = 0; j < NUM_SEV; j++) begin
          sev_cnt[j] <= sev_cnt[j] + CW'(inc_vec[j]) - CW'(dec_vec[j]);
        end
        if (do_ins) begin
          slot_used[free_idx] <= 1'b1;
          active_q            <= active_q + CW'(1);
        end else if (do_clr) begin
          slot_used[found_idx] <= 1'b0;
          active_q             <= active_q - CW'(1);
        end
      end
      if (do_ins) begin
        head <= (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + HW'(1);
        if (fill < FW'(HISTORY_DEPTH)) fill <= fill + FW'(1);
      end
      if (cmd.apply && op_q == OP_FORCE && fm_q <= MODE_DEBUG) begin
        cur_mode <= fm_q;
      end else if (cmd.finish) begin
        cur_mode <= new_mode;
      end
    end
  end

  // outcome of the item, settled before the finish step
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hv_q <= 1'b0;
      case (op_q)
        OP_SET: begin
          st_q  <= found_q ? ST_EXISTING : (free_q ? ST_INSERTED : ST_FULL);
          upd_q <= found_q || free_q;
        end
        OP_CLR: begin
          st_q  <= found_q ? ST_CLEARED : ST_NOTFOUND;
          upd_q <= found_q;
        end
        OP_CLRALL: begin
          st_q  <= ST_DONE;
          upd_q <= 1'b1;
        end
        default: begin
          st_q  <= ST_DONE;
          upd_q <= 1'b0;
        end
      endcase
    end else if (cmd.hist_chk) begin
      hv_q  <= hist_hit;
      st_q  <= hist_hit ? ST_DONE : ST_HINVALID;
      upd_q <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status        <= st_q;
      system_mode   <= new_mode;
      max_severity  <= max_sev;
      active_count  <= active_q;
      hist_valid    <= hv_q;
      hist_source   <= hv_q ? rd_data[26:19] : 8'd0;
      hist_code     <= hv_q ? rd_data[18:3] : 16'd0;
      hist_severity <= hv_q ? rd_data[2:0] : 3'd0;
    end
  end

  assign out_valid = out_valid_q;

  `FTSM_AST_NOW(a_used_matches_count, 1'b1, $countones(slot_used) == int'(active_q), "slot use bits disagree with active count")
  `FTSM_AST_NOW(a_sev_sum, 1'b1, cnt_sum == SUMW'(active_q), "severity counters disagree with active count")
  `FTSM_AST_NOW(a_fill_bound, 1'b1, fill <= FW'(HISTORY_DEPTH), "history fill beyond ring depth")
  `FTSM_AST_NOW(a_hist_status, out_valid_q && hist_valid, status == ST_DONE, "history word with wrong status")
  `FTSM_AST_NEXT(a_finish_loads, cmd.finish, out_valid_q, "finished item did not reach the output")

endmodule

// File: hw/rtl/fault_table_severity_mode_manager_unit.sv
// top level of the fault table and system mode manager
// depends on ftsm_pkg, ftsm_ctrl and ftsm_datapath
//
// input channel (in_valid / in_stall) carries one item: mode (operation),
// fault_source, fault_code, severity, forced_mode and history_age.
// output channel (out_valid / out_stall) returns one word per item: status,
// system_mode, max_severity, active_count and the history fields.
// a set or clear item scans all ACTIVE_SLOTS slots one per cycle, then passes
// the apply and finish steps; its word is loaded at the finish step and the
// next item is taken once the sequencer is back in idle.
// clear-all, force and a history read (through the registered ring read port)
// skip the scan and go from acceptance to the apply or read step, then finish.
// one item is in work at a time.
// the result word sits in an output register; the next item is accepted while
// it waits, and a stalled receiver only holds the block at the finish step of
// the following item.
// reset empties the fault table, the history ring and the counters and puts
// the system mode in init; the block takes items in the cycle after reset.
module fault_table_severity_mode_manager_unit #(
  parameter int ACTIVE_SLOTS  = 16,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        mode,
  input  logic [7:0]                        fault_source,
  input  logic [15:0]                       fault_code,
  input  logic [2:0]                        severity,
  input  logic [3:0]                        forced_mode,
  input  logic [4:0]                        history_age,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [3:0]                        system_mode,
  output logic [2:0]                        max_severity,
  output logic [$clog2(ACTIVE_SLOTS+1)-1:0] active_count,
  output logic                              hist_valid,
  output logic [7:0]                        hist_source,
  output logic [15:0]                       hist_code,
  output logic [2:0]                        hist_severity
);
  import ftsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ftsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftsm_datapath #(
    .ACTIVE_SLOTS  (ACTIVE_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .fault_source  (fault_source),
    .fault_code    (fault_code),
    .severity      (severity),
    .forced_mode   (forced_mode),
    .history_age   (history_age),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .system_mode   (system_mode),
    .max_severity  (max_severity),
    .active_count  (active_count),
    .hist_valid    (hist_valid),
    .hist_source   (hist_source),
    .hist_code     (hist_code),
    .hist_severity (hist_severity)
  );

endmodule
